[hdl/ascii_can_frame_parser_assert.svh]
// ----------------------------------------------------------------------------
// ascii_can_frame_parser_assert.svh
// Assertion macros for the ASCII CAN frame parser; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASCII_CAN_FRAME_PARSER_ASSERT_SVH
`define ASCII_CAN_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ACFP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ACFP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACFP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ACFP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/acfp_pkg.sv]
// ----------------------------------------------------------------------------
// acfp_pkg
// Constants, types and the hex digit decoder of the ASCII CAN frame parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

  // frame layout
  localparam int MAX_DATA_BYTES = 8;
  localparam int ID_HEX_DIGITS  = 8;
  localparam int OUT_BYTES      = 8;
  localparam int POS_W          = 5;

  // characters
  localparam logic [7:0] CHAR_FRAME = 8'h54;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // line positions
  localparam logic [POS_W-1:0] POS_LIMIT      = 5'd31;
  localparam logic [POS_W-1:0] POS_ID_LAST    = POS_W'(ID_HEX_DIGITS);
  localparam logic [POS_W-1:0] POS_LENGTH     = POS_W'(ID_HEX_DIGITS + 1);
  localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(ID_HEX_DIGITS + 2);
  localparam logic [POS_W-1:0] POS_DATA_END   =
    POS_W'(ID_HEX_DIGITS + 2 + 2 * MAX_DATA_BYTES);
  localparam logic [3:0]       LEN_MAX        = 4'(MAX_DATA_BYTES);

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // ascii hex character to nibble
  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    case (c) inside
      [8'h30:8'h39]: h.value = c[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: h.value = c[3:0] + 4'd9;
      default:       h.ok = 1'b0;
    endcase
    return h;
  endfunction

endpackage

[hdl/ascii_can_frame_parser.sv]
// ----------------------------------------------------------------------------
// ascii_can_frame_parser
// Parses carriage-return-terminated ASCII lines into extended CAN frames.
//
// Usage: rx_byte/rx_valid/rx_ready carries one received character per
// transfer. A line starting with 'T' holds 8 hex identifier characters, one
// hex length character and length hex byte pairs; its carriage return puts
// one frame on frame_valid/frame_ready with frame_id, frame_length and
// byte_0..byte_7. Every other line gives no frame.
// Throughput: one character per cycle while rx_ready is high; the line state is
// updated in the same cycle a character transfers.
// Output: the frame appears in the cycle after its carriage return transfers,
// held in the output register until taken.
// Stall: rx_ready stays high while the output register is empty or being
// drained; it drops only while a frame waits and frame_ready is low.
// Reset: rst (synchronous) clears the line state and empties the output.
// ----------------------------------------------------------------------------
`include "ascii_can_frame_parser_assert.svh"

module ascii_can_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       rx_valid,
  output logic       rx_ready,
  output logic [31:0] frame_id,
  output logic [3:0] frame_length,
  output logic [7:0] byte_0,
  output logic [7:0] byte_1,
  output logic [7:0] byte_2,
  output logic [7:0] byte_3,
  output logic [7:0] byte_4,
  output logic [7:0] byte_5,
  output logic [7:0] byte_6,
  output logic [7:0] byte_7,
  output logic       frame_valid,
  input  logic       frame_ready
);
  import acfp_pkg::*;

  // line state
  logic             line_is_frame, line_is_frame_next;
  logic [POS_W-1:0] char_position, char_position_next;
  logic [31:0]      id_accumulator, id_accumulator_next;
  logic [3:0]       length_value, length_value_next;
  logic             field_stopped, field_stopped_next;
  logic [7:0]       data_store [OUT_BYTES];
  logic [7:0]       data_store_next [OUT_BYTES];

  // output register
  logic [7:0]       out_data [OUT_BYTES];

  logic             rx_fire;
  logic             is_cr;
  hex_digit_t       digit;
  logic [POS_W-1:0] data_offset;
  logic [2:0]       byte_sel;
  logic [3:0]       len_sat;

  assign rx_ready = !frame_valid || frame_ready;
  assign rx_fire  = rx_valid && rx_ready;
  assign is_cr    = (rx_byte == CHAR_CR);
  assign digit    = hex_value(rx_byte);

  assign data_offset = char_position - POS_DATA_FIRST;
  assign byte_sel    = data_offset[3:1];
  assign len_sat     = (length_value > LEN_MAX) ? LEN_MAX : length_value;

  // next line state for the current character
  always_comb begin
    line_is_frame_next  = line_is_frame;
    char_position_next  = char_position;
    id_accumulator_next = id_accumulator;
    length_value_next   = length_value;
    field_stopped_next  = field_stopped;
    for (int i = 0; i < OUT_BYTES; i++) begin
      data_store_next[i] = data_store[i];
    end

    if (is_cr) begin
      line_is_frame_next  = 1'b0;
      char_position_next  = '0;
      id_accumulator_next = '0;
      length_value_next   = '0;
      field_stopped_next  = 1'b0;
      for (int i = 0; i < OUT_BYTES; i++) begin
        data_store_next[i] = '0;
      end
    end else begin
      if (char_position == '0) begin
        line_is_frame_next = (rx_byte == CHAR_FRAME);
        field_stopped_next = 1'b0;
      end else if (char_position <= POS_ID_LAST) begin
        if (!field_stopped) begin
          if (digit.ok) begin
            id_accumulator_next = {id_accumulator[27:0], digit.value};
          end else begin
            field_stopped_next = 1'b1;
          end
        end
      end else if (char_position == POS_LENGTH) begin
        length_value_next = digit.ok ? digit.value : 4'd0;
      end else if (char_position < POS_DATA_END) begin
        if (!data_offset[0]) begin
          // first digit of a pair
          data_store_next[byte_sel] = digit.ok ? {4'd0, digit.value} : 8'd0;
          field_stopped_next        = !digit.ok;
        end else if (!field_stopped && digit.ok) begin
          data_store_next[byte_sel] = {data_store[byte_sel][3:0], digit.value};
        end
      end
      if (char_position < POS_LIMIT) begin
        char_position_next = char_position + 1'b1;
      end
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_is_frame  <= 1'b0;
      char_position  <= '0;
      id_accumulator <= '0;
      length_value   <= '0;
      field_stopped  <= 1'b0;
      for (int i = 0; i < OUT_BYTES; i++) begin
        data_store[i] <= '0;
      end
    end else if (rx_fire) begin
      line_is_frame  <= line_is_frame_next;
      char_position  <= char_position_next;
      id_accumulator <= id_accumulator_next;
      length_value   <= length_value_next;
      field_stopped  <= field_stopped_next;
      for (int i = 0; i < OUT_BYTES; i++) begin
        data_store[i] <= data_store_next[i];
      end
    end
  end

  // result register, loaded at the carriage return of a frame line
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else begin
      if (frame_valid && frame_ready) begin
        frame_valid <= 1'b0;
      end
      if (rx_fire && is_cr && line_is_frame) begin
        frame_valid <= 1'b1;
      end
    end
    if (rx_fire && is_cr && line_is_frame) begin
      frame_id     <= id_accumulator;
      frame_length <= len_sat;
      for (int i = 0; i < OUT_BYTES; i++) begin
        out_data[i] <= (4'(i) < len_sat) ? data_store[i] : 8'd0;
      end
    end
  end

  assign byte_0 = out_data[0];
  assign byte_1 = out_data[1];
  assign byte_2 = out_data[2];
  assign byte_3 = out_data[3];
  assign byte_4 = out_data[4];
  assign byte_5 = out_data[5];
  assign byte_6 = out_data[6];
  assign byte_7 = out_data[7];

  // checks
  `ACFP_ASSERT_IMP(a_len_limit, clk, rst, frame_valid, frame_length <= LEN_MAX, "length above limit")
  `ACFP_ASSERT_NXT(a_cr_clears, clk, rst, rx_fire && is_cr, char_position == '0 && !line_is_frame, "line not cleared")
  `ACFP_ASSERT_NXT(a_pos_step, clk, rst, rx_fire && !is_cr && char_position < POS_LIMIT, char_position == $past(char_position) + 1'b1, "position did not advance")
  `ACFP_ASSERT_IMP(a_ready_empty, clk, rst, !frame_valid, rx_ready, "stalled with empty output")

endmodule
